### src/tmtw_pkg.sv
// Shared types, constants and helpers for the text-mode terminal writer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tmtw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int WALK_W  = $clog2(CELLS + 1);

    // Field widths on the ports
    localparam int CHAR_W      = 8;
    localparam int INDEX_IN_W  = 11;
    localparam int OUT_ROW_W   = 5;
    localparam int OUT_COL_W   = 7;
    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 8;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 32;

    // APB register map: register index sits above the byte offset
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

    // Character and cell codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

    typedef enum logic [1:0] {
        REQ_PUT       = 2'd0,
        REQ_BACKSPACE = 2'd1,
        REQ_CLEAR     = 2'd2,
        REQ_READ      = 2'd3
    } req_t;

    // Result beat, cursor row in the lowest bits
    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic                 scrolled;
        logic [OUT_COL_W-1:0] cursor_column;
        logic [OUT_ROW_W-1:0] cursor_row;
    } out_item_t;

    localparam int OUT_W = $bits(out_item_t);

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic clear_step;
        logic scroll_step;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic scroll_need;
        logic walk_last_cell;
        logic walk_end;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/text_mode_terminal_writer_core.sv
// Text-mode terminal writer: a ROWS x COLUMNS screen RAM of 16-bit cells
// (character low byte, attribute high byte) and a cursor. A put of an ordinary
// character or a backspace passes accept and at most one RAM write in execute;
// a read adds a wait for the registered RAM read. Clear sweeps the RAM at one
// cell a cycle, and a scroll copies every row up through the RAM's write and
// read ports at one cell a cycle, zeroing the bottom row. After reset a clearing
// pass over all CELLS cells (2000 at 80 x 25) fills the RAM with blanks
// before the first input beat is accepted; APB writes are taken throughout.
// One request is in flight at a time; a finished result waits in the output
// register while the next beat is accepted.
// Depends on tmtw_pkg, tmtw_ctrl, tmtw_dp and tmtw_ram.
`default_nettype none

module text_mode_terminal_writer_core import tmtw_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Request beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [7:0] char_code, [18:8] cell_index
    input  wire logic [S_TUSER_W-1:0]  s_tuser,  // [1:0] req_type
    // Result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata   // [4:0] cursor_row, [11:5] cursor_column,
                                                 // [12] scrolled, [28:13] cell_data
);

    logic [COLOR_W-1:0] color_reg;
    logic               cfg_write;
    dp_cmd_t            cmd;
    dp_status_t         status;
    out_item_t          m_item;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= TEXT_COLOR_RESET;
        end else if (cfg_write && paddr[2] == REG_TEXT_COLOR) begin
            color_reg <= pwdata[COLOR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TEXT_COLOR) ?
                    {{(APB_DATA_W - COLOR_W){1'b0}}, color_reg} : '0;

    tmtw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tmtw_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_req     (s_tuser),
        .in_char    (s_tdata[CHAR_W-1:0]),
        .in_index   (s_tdata[CHAR_W +: INDEX_IN_W]),
        .text_color (color_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_item     (m_item)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, m_item};

    // One request in flight: no beat accepted right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request beat accepted while previous one in flight");

    // A scroll always leaves the cursor at the start of the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_item.scrolled) |->
        (m_item.cursor_column == '0 && m_item.cursor_row == OUT_ROW_W'(ROWS - 1)))
        else $error("scrolled result with cursor off the last row start");

    // Start-up clearing pass holds off input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("input ready before start-up clear");

endmodule

`default_nettype wire

### src/tmtw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone: no package needed.
`default_nettype none

module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/tmtw_ctrl.sv
// Sequencer for the terminal writer: start-up clear, request execution,
// clear and scroll sweeps, result hand-off. Depends on tmtw_pkg.
`default_nettype none

module tmtw_ctrl import tmtw_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_CLEAR  = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clear_step = 1'b1;
                if (status.walk_last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (status.req) inside
                    REQ_PUT, REQ_BACKSPACE: begin
                        if (status.scroll_need) begin
                            state_next = ST_SCROLL;
                        end else if (status.out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                    REQ_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.walk_last_cell) begin
                    state_next = ST_OUT;
                end
            end
            ST_SCROLL: begin
                cmd.scroll_step = 1'b1;
                if (status.walk_end) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

endmodule

`default_nettype wire

### src/tmtw_dp.sv
// Datapath of the terminal writer: request latch, cursor, sweep counter,
// screen RAM ports and result register. Depends on tmtw_pkg and tmtw_ram.
`default_nettype none

module tmtw_dp import tmtw_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic [S_TUSER_W-1:0]  in_req,
    input  wire logic [CHAR_W-1:0]     in_char,
    input  wire logic [INDEX_IN_W-1:0] in_index,
    input  wire logic [COLOR_W-1:0]    text_color,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output out_item_t                  m_item
);

    req_t                  req_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [INDEX_IN_W-1:0] index_reg;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  scroll_reg;
    logic [WALK_W-1:0]     walk_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic                  scroll_need;
    logic                  line_end;
    logic                  at_bottom;
    logic                  cell_ok;
    logic [IDX_W-1:0]      cur_addr;
    logic [WALK_W:0]       walk_plus_cols;
    logic [WALK_W-1:0]     walk_minus1;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [CELL_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [CELL_W-1:0]     ram_rdata;

    assign line_end  = (col_reg == COL_W'(COLUMNS - 1));
    assign at_bottom = (row_reg == ROW_W'(ROWS - 1));
    assign cell_ok   = (32'(index_reg) < CELLS);
    assign cur_addr  = IDX_W'(row_reg * COLUMNS) + IDX_W'(col_reg);
    assign walk_plus_cols = {1'b0, walk_reg} + (WALK_W + 1)'(COLUMNS);
    assign walk_minus1    = walk_reg - 1'b1;

    // Cursor after the latched request
    always_comb begin
        row_next    = row_reg;
        col_next    = col_reg;
        scroll_need = 1'b0;
        case (req_reg)
            REQ_PUT: begin
                if (char_reg == NEWLINE_CODE || line_end) begin
                    col_next = '0;
                    if (at_bottom) begin
                        scroll_need = 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            REQ_BACKSPACE: begin
                if (col_reg != '0) begin
                    col_next = col_reg - 1'b1;
                end else if (row_reg != '0) begin
                    row_next = row_reg - 1'b1;
                end
            end
            REQ_CLEAR: begin
                row_next = '0;
                col_next = '0;
            end
            default: ;
        endcase
    end

    // Screen RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = IDX_W'(index_reg);
        if (cmd.exec) begin
            case (req_reg)
                REQ_PUT: begin
                    ram_we    = (char_reg != NEWLINE_CODE);
                    ram_wdata = {text_color, char_reg};
                end
                REQ_BACKSPACE: begin
                    ram_we    = (col_reg != '0);
                    ram_waddr = cur_addr - 1'b1;
                    ram_wdata = {text_color, SPACE_CODE};
                end
                REQ_READ: ram_re = cell_ok;
                default: ;
            endcase
        end
        if (cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = walk_reg[IDX_W-1:0];
            ram_wdata = BLANK_CELL;
        end
        // Read one row below, write one step behind; bottom row gets zeros
        if (cmd.scroll_step) begin
            ram_re    = (walk_reg < WALK_W'(CELLS - COLUMNS));
            ram_raddr = walk_plus_cols[IDX_W-1:0];
            ram_we    = (walk_reg != '0);
            ram_waddr = walk_minus1[IDX_W-1:0];
            ram_wdata = (walk_reg <= WALK_W'(CELLS - COLUMNS)) ? ram_rdata : '0;
        end
    end

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Latch the request beat
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= req_t'(in_req);
            char_reg  <= in_char;
            index_reg <= in_index;
        end
    end

    // Cursor, scroll flag and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            col_reg    <= '0;
            scroll_reg <= 1'b0;
            walk_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                scroll_reg <= 1'b0;
            end
            if (cmd.exec) begin
                row_reg    <= row_next;
                col_reg    <= col_next;
                scroll_reg <= scroll_need;
                walk_reg   <= '0;
            end else if (cmd.clear_step || cmd.scroll_step) begin
                walk_reg <= walk_reg + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Take the cursor being updated in the execute cycle, else the stored one
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.cursor_row    <= cmd.exec ? OUT_ROW_W'(row_next) : OUT_ROW_W'(row_reg);
            out_reg.cursor_column <= cmd.exec ? OUT_COL_W'(col_next) : OUT_COL_W'(col_reg);
            out_reg.scrolled      <= scroll_reg;
            out_reg.cell_data     <= (req_reg == REQ_READ && cell_ok) ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_item   = out_reg;

    assign status.req            = req_reg;
    assign status.scroll_need    = scroll_need;
    assign status.walk_last_cell = (walk_reg == WALK_W'(CELLS - 1));
    assign status.walk_end       = (walk_reg == WALK_W'(CELLS));
    assign status.out_free       = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Testbench for text_mode_terminal_writer_core: directed and random request beats,
// checked against a cycle-free model of the screen store and cursor kept here.
// Depends on tmtw_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top import tmtw_pkg::*;;

    // Sender and receiver behaviour per traffic phase
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    localparam int ITEMS_PER_PHASE = 440;
    localparam int MAX_INDEX       = (1 << INDEX_IN_W) - 1;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Model of the block: screen store, cursor and attribute register
    logic [CELL_W-1:0]  screen_model [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] color_model;

    out_item_t expected_results [$];
    int        mismatch_count = 0;
    int        accepted_beats = 0;
    int        sender_gap_pct = 0;
    int        sink_stall_pct = 0;

    text_mode_terminal_writer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] char_code, [18:8] cell_index
        .s_tuser  (s_tuser),   // [1:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [4:0] cursor_row, [11:5] cursor_column, [12] scrolled,
                               // [28:13] cell_data
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Fill the store with blanks and home the cursor
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Move the cursor down one row, scrolling the store when already on the last row
    function automatic logic step_down_row();
        if (cur_row + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
            cur_row = ROWS - 1;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    // Apply one request to the model and return the result beat it causes
    function automatic out_item_t predict_request(input req_t rq, input logic [CHAR_W-1:0] ch,
                                                  input logic [INDEX_IN_W-1:0] ix);
        out_item_t res;
        logic      did_scroll;
        res        = '0;
        did_scroll = 1'b0;
        case (rq)
            REQ_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    cur_col    = 0;
                    did_scroll = step_down_row();
                end else begin
                    screen_model[cur_row * COLUMNS + cur_col] = {color_model, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col    = 0;
                        did_scroll = step_down_row();
                    end
                end
            end
            REQ_BACKSPACE: begin
                if (cur_col != 0) begin
                    cur_col--;
                    screen_model[cur_row * COLUMNS + cur_col] = {color_model, SPACE_CODE};
                end else if (cur_row != 0) begin
                    cur_row--;
                end
            end
            REQ_CLEAR: blank_screen();
            default: begin
                if (ix < CELLS) res.cell_data = screen_model[ix];
            end
        endcase
        res.cursor_row    = OUT_ROW_W'(cur_row);
        res.cursor_column = OUT_COL_W'(cur_col);
        res.scrolled      = did_scroll;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare one result beat with the oldest pending expectation
    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        out_item_t got;
        out_item_t want;
        got = out_item_t'(beat[OUT_W-1:0]);
        if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing pending", beat, 0);
        end else begin
            want = expected_results.pop_front();
            if (got.cursor_row != want.cursor_row)
                report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
            if (got.cursor_column != want.cursor_column)
                report_mismatch("cursor_column", got.cursor_column, want.cursor_column);
            if (got.scrolled != want.scrolled)
                report_mismatch("scrolled", got.scrolled, want.scrolled);
            if (got.cell_data != want.cell_data)
                report_mismatch("cell_data", got.cell_data, want.cell_data);
            if (beat[M_TDATA_W-1:OUT_W] != '0)
                report_mismatch("m_tdata padding", beat[M_TDATA_W-1:OUT_W], 0);
        end
    endtask

    // Receiver: check each accepted beat, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Offer one request beat, hold it until accepted, then record its expectation
    task automatic send_request(input req_t rq, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_IN_W-1:0] ix);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({ix, ch});
        s_tuser  <= rq;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_request(rq, ch, ix));
        accepted_beats++;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Setup and access phase, then the bus is left idle
    task automatic write_text_color(input logic [COLOR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_TEXT_COLOR) << 2;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        color_model = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_text_color();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(REG_TEXT_COLOR) << 2;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata != APB_DATA_W'(color_model))
            report_mismatch("text_color readback", prdata, color_model);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE:        begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
            FLOW_SENDER_GAPS: begin sender_gap_pct = 76; sink_stall_pct = 0;  end
            FLOW_SINK_STALLS: begin sender_gap_pct = 0;  sink_stall_pct = 76; end
            default:          begin sender_gap_pct = 25; sink_stall_pct = 25; end
        endcase
    endtask

    // Read address: near the cursor, anywhere in the store, or anywhere the field allows
    function automatic logic [INDEX_IN_W-1:0] pick_index();
        int pick;
        int at;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            at = cur_row * COLUMNS + cur_col + int'($urandom_range(0, 6)) - 3;
            if (at < 0) at = 0;
            if (at > MAX_INDEX) at = MAX_INDEX;
            return INDEX_IN_W'(at);
        end
        if (pick < 8) return INDEX_IN_W'($urandom_range(0, CELLS - 1));
        return INDEX_IN_W'($urandom_range(0, MAX_INDEX));
    endfunction

    task automatic test_register_access();
        check_text_color();
        write_text_color(8'h00);
        check_text_color();
        write_text_color(8'hFF);
        check_text_color();
    endtask

    // Field extremes, every request kind and the corner cases of the cursor
    task automatic test_directed_requests();
        set_flow(FLOW_FREE);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'hFF, 11'd1999);
        // backspace at top-left leaves everything alone
        send_request(REQ_BACKSPACE, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'hFF, 11'd2047);
        send_request(REQ_PUT, 8'h41, 11'd0);
        // blank the previous cell
        send_request(REQ_BACKSPACE, 8'hFF, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1);
        send_request(REQ_READ, 8'h00, 11'd2);
        send_request(REQ_PUT, NEWLINE_CODE, 11'd0);
        // backspace at column 0 only moves up a row
        send_request(REQ_BACKSPACE, 8'h00, 11'd0);
        send_request(REQ_BACKSPACE, 8'h00, 11'd0);
        // reads outside the store give zero
        send_request(REQ_READ, 8'h00, 11'd2000);
        send_request(REQ_READ, 8'h00, 11'd2047);
        send_request(REQ_PUT, NEWLINE_CODE, 11'd2047);
        send_request(REQ_PUT, 8'h7F, 11'd1024);
        send_request(REQ_READ, 8'hFF, 11'd80);
        send_request(REQ_CLEAR, 8'hFF, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1999);
        // clear keeps the configured attribute
        send_request(REQ_PUT, 8'h5A, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd0);
        wait_idle();
    endtask

    // Runs of text, newlines, backspaces and reads, with some noise and clears
    task automatic test_random_traffic(input flow_mode_t mode, input logic [COLOR_W-1:0] color,
                                       input int beats);
        int   first_beat;
        int   run_kind;
        int   run_len;
        logic [CHAR_W-1:0] ch;
        first_beat = accepted_beats;
        write_text_color(color);
        check_text_color();
        set_flow(mode);
        while (accepted_beats - first_beat < beats) begin
            run_kind = $urandom_range(0, 99);
            if (run_kind < 45) run_len = $urandom_range(1, 90);
            else if (run_kind < 60) run_len = $urandom_range(1, 26);
            else if (run_kind < 75) run_len = $urandom_range(1, 40);
            else if (run_kind < 92) run_len = $urandom_range(1, 20);
            else if (run_kind < 97) run_len = $urandom_range(1, 10);
            else run_len = 1;
            for (int k = 0; k < run_len && accepted_beats - first_beat < beats; k++) begin
                ch = CHAR_W'($urandom_range(0, 255));
                if (run_kind < 45) begin
                    if ($urandom_range(0, 19) == 0) ch = NEWLINE_CODE;
                    send_request(REQ_PUT, ch, pick_index());
                end else if (run_kind < 60) begin
                    if ($urandom_range(0, 9) != 0) ch = NEWLINE_CODE;
                    send_request(REQ_PUT, ch, pick_index());
                end else if (run_kind < 75) begin
                    if ($urandom_range(0, 4) == 0) send_request(REQ_READ, ch, pick_index());
                    else send_request(REQ_BACKSPACE, ch, pick_index());
                end else if (run_kind < 92) begin
                    send_request(REQ_READ, ch, pick_index());
                end else if (run_kind < 97) begin
                    send_request(req_t'($urandom_range(0, 3)), ch,
                                 INDEX_IN_W'($urandom_range(0, MAX_INDEX)));
                end else begin
                    send_request(REQ_CLEAR, ch, pick_index());
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        blank_screen();
        color_model = TEXT_COLOR_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_directed_requests();
        test_random_traffic(FLOW_FREE,        8'h00, ITEMS_PER_PHASE);
        test_random_traffic(FLOW_SENDER_GAPS, 8'hFF, ITEMS_PER_PHASE);
        test_random_traffic(FLOW_SINK_STALLS, COLOR_W'($urandom_range(1, 254)), ITEMS_PER_PHASE);
        test_random_traffic(FLOW_BOTH,        COLOR_W'($urandom_range(0, 255)), ITEMS_PER_PHASE);

        // catch any stray beat after the last expected one
        repeat (CELLS + 100) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog: about 1800 beats, even if each took a full store walk plus stalls,
    // finish well before this limit; reaching it reports failure.
    initial begin
        #200_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### text_mode_terminal_writer_core.f
src/tmtw_pkg.sv
src/tmtw_ram.sv
src/tmtw_ctrl.sv
src/tmtw_dp.sv
src/text_mode_terminal_writer_core.sv
bench/tb_top.sv
